// File: rtl/rrlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrlm_pkg
// Shared types, codes and helpers for the ring record log manager: item and
// result codes, record layout constants, sequencer states and the CRC step.
// ----------------------------------------------------------------------------
package rrlm_pkg;

   // record slot addressing
   localparam int SLOT_W     = 7;
   localparam int SLOT_COUNT = 128;
   localparam logic [SLOT_W:0] SLOT_COUNT_SUM = (SLOT_W + 1)'(SLOT_COUNT);

   // record layout
   localparam int            REC_BYTES   = 16;
   localparam logic [3:0]    REC_LAST    = 4'(REC_BYTES - 1);
   localparam logic [3:0]    CRC_SPAN    = 4'd14;
   localparam logic [3:0]    CRC_LAST    = 4'(CRC_SPAN - 1);
   localparam logic [3:0]    CRC_LO_POS  = 4'd14;
   localparam logic [3:0]    SCAN_FIELD_END = 4'd10;
   localparam logic [15:0]   CRC_INIT    = 16'hFFFF;
   localparam logic [15:0]   CRC_POLY    = 16'h1021;
   localparam logic [15:0]   MAGIC_RESET = 16'h544D;

   // item operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_SCAN  = 2'd1;
   localparam logic [1:0] OP_SAVE  = 2'd2;
   localparam logic [1:0] OP_LOAD  = 2'd3;

   // result kind codes
   localparam logic [2:0] KIND_CLEAR_ACK = 3'd0;
   localparam logic [2:0] KIND_VERDICT   = 3'd1;
   localparam logic [2:0] KIND_REC_BYTE  = 3'd2;
   localparam logic [2:0] KIND_LOAD      = 3'd3;
   localparam logic [2:0] KIND_SKIPPED   = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_CRC,
      ST_SAVE_CRC,
      ST_SAVE_EMIT,
      ST_REPLY
   } seq_state_type;

   // one result item
   typedef struct packed {
      logic [2:0]         kind;
      logic [SLOT_W-1:0]  out_slot;
      logic [3:0]         out_byte_index;
      logic [7:0]         out_byte;
      logic               last;
      logic signed [31:0] out_value;
      logic [31:0]        out_sequence;
      logic               flag;
   } rsp_type;

   // one bit of the msb-first crc-16 shift
   function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
      logic [15:0] shifted;
      shifted = {crc[14:0], 1'b0};
      return crc[15] ? (shifted ^ CRC_POLY) : shifted;
   endfunction

endpackage

// File: rtl/ring_record_log_manager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_record_log_manager_core
// Keeps the latest record of a wear-levelled ring of 16-byte records, checks
// scanned pages (magic word and crc-16) and builds new records on save.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | contents
//  ---------+-----------+------------------------+-------------------------------
//  req_     | in        | req_valid / req_ready  | op, slot, byte position, byte,
//           |           |                        | value to save
//  rsp_     | out       | rsp_valid / rsp_ready  | kind, slot, byte position,
//           |           |                        | byte, last, value, seq, flag
//  csr_     | in        | csr_wr_en              | record magic word
//
//  One bit-serial crc unit does all crc work, one bit per cycle.
//  Scan byte 0..13: accept, decode, then 8 crc bits; other scan bytes,
//  clear and load: accept, decode and any reply, plus any wait on rsp_ready.
//  Save: accept, decode, crc over 14 bytes x 8 bits, then 16 result items,
//  one per cycle while rsp_ready is high; a skipped save goes through
//  accept, decode and reply. Synchronous reset clears the latest record
//  and restarts the crc; req_ready is high only between items, and a
//  waiting final result does not hold off the next item.
//
module ring_record_log_manager_core (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [rrlm_pkg::SLOT_W-1:0] req_slot_index,
   input  logic [3:0]                  req_byte_index,
   input  logic [7:0]                  req_page_byte,
   input  logic signed [31:0]          req_new_value,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_kind,
   output logic [rrlm_pkg::SLOT_W-1:0] rsp_out_slot,
   output logic [3:0]                  rsp_out_byte_index,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last,
   output logic signed [31:0]          rsp_out_value,
   output logic [31:0]                 rsp_out_sequence,
   output logic                        rsp_flag,

   input  logic                        csr_wr_en,
   input  logic [15:0]                 csr_wr_data
);

   // sequencer
   rrlm_pkg::seq_state_type state_ff, state_in;

   // captured item
   logic [1:0]                  op_ff;
   logic [rrlm_pkg::SLOT_W-1:0] slot_ff;
   logic [3:0]                  bidx_ff;
   logic [7:0]                  byte_ff;
   logic signed [31:0]          nval_ff;

   // configuration
   logic [15:0] magic_ff;

   // latest record
   logic [31:0]                 latest_seq_ff, latest_seq_in;
   logic [rrlm_pkg::SLOT_W-1:0] latest_slot_ff, latest_slot_in;
   logic signed [31:0]          latest_value_ff, latest_value_in;
   logic                        have_record_ff, have_record_in;

   // scan state: running crc, record bytes 0..9 and stored crc low byte
   logic [15:0] scan_crc_ff, scan_crc_in;
   logic [79:0] scan_fields_ff, scan_fields_in;
   logic [7:0]  scan_crc_lo_ff, scan_crc_lo_in;

   // shared crc unit and counters
   logic [15:0] crc_ff, crc_in;
   logic [2:0]  bit_cnt_ff, bit_cnt_in;
   logic [3:0]  byte_cnt_ff, byte_cnt_in;

   // record under construction
   logic [rrlm_pkg::SLOT_W-1:0] save_slot_ff, save_slot_in;
   logic [31:0]                 save_seq_ff, save_seq_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rrlm_pkg::rsp_type rsp_ff, rsp_in;

   // helpers
   logic                        req_accept;
   logic                        out_free;
   logic                        push;
   logic                        save_skip;
   logic [rrlm_pkg::SLOT_W:0]   slot_sum;
   logic [rrlm_pkg::SLOT_W-1:0] next_slot;
   logic [127:0]                rec_vec;
   logic [7:0]                  rec_byte;
   logic [7:0]                  cur_byte;
   logic [15:0]                 crc_feed;
   logic [15:0]                 crc_next;
   logic                        scan_ok;
   logic [31:0]                 seq_diff;
   logic                        taken;
   rrlm_pkg::rsp_type           reply;

   assign req_ready  = (state_ff == rrlm_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign save_skip  = have_record_ff && (nval_ff == latest_value_ff);

   // next slot in the ring, wrapping at the slot count
   assign slot_sum  = {1'b0, latest_slot_ff} + (rrlm_pkg::SLOT_W + 1)'(1);
   assign next_slot = (slot_sum >= rrlm_pkg::SLOT_COUNT_SUM) ?
                      rrlm_pkg::SLOT_W'(slot_sum - rrlm_pkg::SLOT_COUNT_SUM) :
                      rrlm_pkg::SLOT_W'(slot_sum);

   // record image, little-endian: magic, sequence, value, zeros, crc
   assign rec_vec  = {crc_ff, 32'h0, nval_ff, save_seq_ff, magic_ff};
   assign rec_byte = rec_vec[{byte_cnt_ff, 3'b000} +: 8];

   // shared crc unit: merge the byte on the first bit, then one shift
   assign cur_byte = (op_ff == rrlm_pkg::OP_SCAN) ? byte_ff : rec_byte;
   assign crc_feed = (bit_cnt_ff == 3'd0) ? (crc_ff ^ {cur_byte, 8'h00}) : crc_ff;
   assign crc_next = rrlm_pkg::crc_bit_step(crc_feed);

   // scan verdict on the final page byte
   assign scan_ok  = (scan_fields_ff[15:0] == magic_ff) &&
                     ({byte_ff, scan_crc_lo_ff} == scan_crc_ff);
   assign seq_diff = scan_fields_ff[47:16] - latest_seq_ff;
   assign taken    = scan_ok &&
                     (!have_record_ff || ((seq_diff != 32'h0) && !seq_diff[31]));

   // single-result reply per op
   always_comb begin
      reply = '0;
      reply.last = 1'b1;
      case (op_ff)
         rrlm_pkg::OP_CLEAR: begin
            reply.kind = rrlm_pkg::KIND_CLEAR_ACK;
         end
         rrlm_pkg::OP_SCAN: begin
            reply.kind         = rrlm_pkg::KIND_VERDICT;
            reply.out_slot     = slot_ff;
            reply.out_value    = taken ? signed'(scan_fields_ff[79:48]) : latest_value_ff;
            reply.out_sequence = taken ? scan_fields_ff[47:16] : latest_seq_ff;
            reply.flag         = taken;
         end
         rrlm_pkg::OP_SAVE: begin
            reply.kind         = rrlm_pkg::KIND_SKIPPED;
            reply.out_slot     = latest_slot_ff;
            reply.out_value    = latest_value_ff;
            reply.out_sequence = latest_seq_ff;
            reply.flag         = 1'b1;
         end
         rrlm_pkg::OP_LOAD: begin
            reply.kind         = rrlm_pkg::KIND_LOAD;
            reply.out_slot     = latest_slot_ff;
            reply.out_value    = have_record_ff ? latest_value_ff : 32'sh0;
            reply.out_sequence = have_record_ff ? latest_seq_ff : 32'h0;
            reply.flag         = have_record_ff;
         end
         default: begin
            reply.kind = rrlm_pkg::KIND_CLEAR_ACK;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrlm_pkg::ST_IDLE: begin
            if (req_accept) state_in = rrlm_pkg::ST_DECODE;
         end
         rrlm_pkg::ST_DECODE: begin
            case (op_ff)
               rrlm_pkg::OP_SCAN: begin
                  if (bidx_ff < rrlm_pkg::CRC_SPAN)
                     state_in = rrlm_pkg::ST_SCAN_CRC;
                  else if (bidx_ff == rrlm_pkg::REC_LAST)
                     state_in = rrlm_pkg::ST_REPLY;
                  else
                     state_in = rrlm_pkg::ST_IDLE;
               end
               rrlm_pkg::OP_SAVE: begin
                  state_in = save_skip ? rrlm_pkg::ST_REPLY : rrlm_pkg::ST_SAVE_CRC;
               end
               default: state_in = rrlm_pkg::ST_REPLY;
            endcase
         end
         rrlm_pkg::ST_SCAN_CRC: begin
            if (bit_cnt_ff == 3'd7) state_in = rrlm_pkg::ST_IDLE;
         end
         rrlm_pkg::ST_SAVE_CRC: begin
            if (bit_cnt_ff == 3'd7 && byte_cnt_ff == rrlm_pkg::CRC_LAST)
               state_in = rrlm_pkg::ST_SAVE_EMIT;
         end
         rrlm_pkg::ST_SAVE_EMIT: begin
            if (out_free && byte_cnt_ff == rrlm_pkg::REC_LAST)
               state_in = rrlm_pkg::ST_IDLE;
         end
         rrlm_pkg::ST_REPLY: begin
            if (out_free) state_in = rrlm_pkg::ST_IDLE;
         end
         default: state_in = rrlm_pkg::ST_IDLE;
      endcase
   end

   // datapath control per state
   always_comb begin
      latest_seq_in   = latest_seq_ff;
      latest_slot_in  = latest_slot_ff;
      latest_value_in = latest_value_ff;
      have_record_in  = have_record_ff;
      scan_crc_in     = scan_crc_ff;
      scan_fields_in  = scan_fields_ff;
      scan_crc_lo_in  = scan_crc_lo_ff;
      crc_in          = crc_ff;
      bit_cnt_in      = bit_cnt_ff;
      byte_cnt_in     = byte_cnt_ff;
      save_slot_in    = save_slot_ff;
      save_seq_in     = save_seq_ff;
      push            = 1'b0;
      rsp_in          = rsp_ff;

      case (state_ff)
         rrlm_pkg::ST_DECODE: begin
            bit_cnt_in  = 3'd0;
            byte_cnt_in = 4'd0;
            if (op_ff == rrlm_pkg::OP_SCAN) begin
               // keep the byte by its position, seed the crc
               if (bidx_ff < rrlm_pkg::SCAN_FIELD_END)
                  scan_fields_in[{bidx_ff[3:0], 3'b000} +: 8] = byte_ff;
               if (bidx_ff == rrlm_pkg::CRC_LO_POS)
                  scan_crc_lo_in = byte_ff;
               crc_in = (bidx_ff == 4'd0) ? rrlm_pkg::CRC_INIT : scan_crc_ff;
            end else if (op_ff == rrlm_pkg::OP_SAVE) begin
               save_slot_in = have_record_ff ? next_slot : '0;
               save_seq_in  = have_record_ff ? (latest_seq_ff + 32'd1) : 32'd1;
               crc_in       = rrlm_pkg::CRC_INIT;
            end
         end
         rrlm_pkg::ST_SCAN_CRC: begin
            crc_in     = crc_next;
            bit_cnt_in = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd7) scan_crc_in = crc_next;
         end
         rrlm_pkg::ST_SAVE_CRC: begin
            crc_in     = crc_next;
            bit_cnt_in = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd7)
               byte_cnt_in = (byte_cnt_ff == rrlm_pkg::CRC_LAST) ?
                             4'd0 : (byte_cnt_ff + 4'd1);
         end
         rrlm_pkg::ST_SAVE_EMIT: begin
            if (out_free) begin
               push                  = 1'b1;
               rsp_in.kind           = rrlm_pkg::KIND_REC_BYTE;
               rsp_in.out_slot       = save_slot_ff;
               rsp_in.out_byte_index = byte_cnt_ff;
               rsp_in.out_byte       = rec_byte;
               rsp_in.last           = (byte_cnt_ff == rrlm_pkg::REC_LAST);
               rsp_in.out_value      = nval_ff;
               rsp_in.out_sequence   = save_seq_ff;
               rsp_in.flag           = 1'b0;
               byte_cnt_in           = byte_cnt_ff + 4'd1;
               if (byte_cnt_ff == rrlm_pkg::REC_LAST) begin
                  latest_slot_in  = save_slot_ff;
                  latest_seq_in   = save_seq_ff;
                  latest_value_in = nval_ff;
                  have_record_in  = 1'b1;
               end
            end
         end
         rrlm_pkg::ST_REPLY: begin
            if (out_free) begin
               push   = 1'b1;
               rsp_in = reply;
               if (op_ff == rrlm_pkg::OP_CLEAR) begin
                  have_record_in = 1'b0;
               end else if (op_ff == rrlm_pkg::OP_SCAN && taken) begin
                  latest_seq_in   = scan_fields_ff[47:16];
                  latest_slot_in  = slot_ff;
                  latest_value_in = signed'(scan_fields_ff[79:48]);
                  have_record_in  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // output register valid
   assign rsp_valid_in = push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rrlm_pkg::ST_IDLE;
         magic_ff        <= rrlm_pkg::MAGIC_RESET;
         latest_seq_ff   <= 32'h0;
         latest_slot_ff  <= '0;
         latest_value_ff <= 32'sh0;
         have_record_ff  <= 1'b0;
         scan_crc_ff     <= rrlm_pkg::CRC_INIT;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         latest_seq_ff   <= latest_seq_in;
         latest_slot_ff  <= latest_slot_in;
         latest_value_ff <= latest_value_in;
         have_record_ff  <= have_record_in;
         scan_crc_ff     <= scan_crc_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) magic_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_op;
         slot_ff <= req_slot_index;
         bidx_ff <= req_byte_index;
         byte_ff <= req_page_byte;
         nval_ff <= req_new_value;
      end
      scan_fields_ff <= scan_fields_in;
      scan_crc_lo_ff <= scan_crc_lo_in;
      crc_ff         <= crc_in;
      bit_cnt_ff     <= bit_cnt_in;
      byte_cnt_ff    <= byte_cnt_in;
      save_slot_ff   <= save_slot_in;
      save_seq_ff    <= save_seq_in;
      rsp_ff         <= rsp_in;
   end

   // result ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_out_slot       = rsp_ff.out_slot;
   assign rsp_out_byte_index = rsp_ff.out_byte_index;
   assign rsp_out_byte       = rsp_ff.out_byte;
   assign rsp_last           = rsp_ff.last;
   assign rsp_out_value      = rsp_ff.out_value;
   assign rsp_out_sequence   = rsp_ff.out_sequence;
   assign rsp_flag           = rsp_ff.flag;

endmodule

// File: tb/ring_record_log_manager_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_record_log_manager_core_tb
// Self-checking bench for the record log core: a queue-fed driver offers
// clear, scan, save and load items with random gaps, a monitor accepts
// results with random stalls, and an in-bench model of the latest record,
// scan crc and record builder predicts every result, checked field by field.
// ----------------------------------------------------------------------------
module ring_record_log_manager_core_tb;

   // one request item as the driver holds it
   typedef struct {
      logic [1:0]                  op;
      logic [rrlm_pkg::SLOT_W-1:0] slot;
      logic [3:0]                  pos;
      logic [7:0]                  data;
      logic [31:0]                 value;
   } log_req_type;

   // 16 record bytes, byte 0 in the low lane
   typedef logic [15:0][7:0] rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_op = rrlm_pkg::OP_LOAD;
   logic [rrlm_pkg::SLOT_W-1:0] req_slot_index = '0;
   logic [3:0]                  req_byte_index = '0;
   logic [7:0]                  req_page_byte = '0;
   logic signed [31:0]          req_new_value = '0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [2:0]                  rsp_kind;
   logic [rrlm_pkg::SLOT_W-1:0] rsp_out_slot;
   logic [3:0]                  rsp_out_byte_index;
   logic [7:0]                  rsp_out_byte;
   logic                        rsp_last;
   logic signed [31:0]          rsp_out_value;
   logic [31:0]                 rsp_out_sequence;
   logic                        rsp_flag;

   logic                        csr_wr_en = 1'b0;
   logic [15:0]                 csr_wr_data = '0;

   ring_record_log_manager_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_slot_index     (req_slot_index),
      .req_byte_index     (req_byte_index),
      .req_page_byte      (req_page_byte),
      .req_new_value      (req_new_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_out_slot       (rsp_out_slot),
      .rsp_out_byte_index (rsp_out_byte_index),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last),
      .rsp_out_value      (rsp_out_value),
      .rsp_out_sequence   (rsp_out_sequence),
      .rsp_flag           (rsp_flag),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // bench bookkeeping
   log_req_type       pending_reqs[$];
   rrlm_pkg::rsp_type expected_rsps[$];
   int                pushed_count = 0;
   int                accepted_count = 0;
   int                fail_count = 0;
   logic              req_fire = 1'b0;
   logic              rsp_fire = 1'b0;
   logic              hold_on = 1'b0;
   int                tx_wait = 0;
   int                rx_wait = 0;
   logic              tx_calm = 1'b0;
   logic              rx_calm = 1'b0;

   // model of the latest record and the scan in progress
   logic [31:0]                 lt_seq = '0;
   logic [rrlm_pkg::SLOT_W-1:0] lt_slot = '0;
   logic [31:0]                 lt_value = '0;
   logic                        lt_valid = 1'b0;
   logic [15:0]                 scan_crc_acc = rrlm_pkg::CRC_INIT;
   logic [7:0]                  page_img[16];
   logic [15:0]                 magic_cfg = rrlm_pkg::MAGIC_RESET;

   // generator hints, only to steer the random records toward newer sequences
   logic [31:0]       seq_hint = '0;
   logic [31:0]       value_hint = '0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("ring_record_log_manager_core verification failed");
      $finish;
   end

   // crc-16 ccitt, msb first, one byte
   function automatic logic [15:0] crc16_ccitt_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      int          i;
      c = crc ^ {b, 8'h00};
      for (i = 0; i < 8; i++)
         c = c[15] ? ({c[14:0], 1'b0} ^ rrlm_pkg::CRC_POLY) : {c[14:0], 1'b0};
      return c;
   endfunction

   // little-endian record with crc over the first 14 bytes
   function automatic rec_type build_record(logic [15:0] magic, logic [31:0] seq,
                                            logic [31:0] value);
      rec_type     r;
      logic [15:0] crc;
      int          i;
      r = '0;
      r[1:0] = magic;
      r[5:2] = seq;
      r[9:6] = value;
      crc = rrlm_pkg::CRC_INIT;
      for (i = 0; i < rrlm_pkg::CRC_SPAN; i++)
         crc = crc16_ccitt_byte(crc, r[i]);
      r[15:14] = crc;
      return r;
   endfunction

   function automatic int draw_idle(logic calm);
      return calm ? 0 : int'($urandom_range(0, 12));
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   function automatic void expect_rsp(logic [2:0] kind,
                                      logic [rrlm_pkg::SLOT_W-1:0] slot,
                                      logic [3:0] pos, logic [7:0] data, logic last,
                                      logic [31:0] value, logic [31:0] seq,
                                      logic flag);
      rrlm_pkg::rsp_type r;
      r.kind           = kind;
      r.out_slot       = slot;
      r.out_byte_index = pos;
      r.out_byte       = data;
      r.last           = last;
      r.out_value      = value;
      r.out_sequence   = seq;
      r.flag           = flag;
      expected_rsps.push_back(r);
   endfunction

   // expected results of one accepted item
   task automatic predict_log_results(log_req_type it);
      logic [15:0]                 magic;
      logic [15:0]                 stored;
      logic [31:0]                 seq;
      logic [31:0]                 val;
      logic [31:0]                 diff;
      logic                        taken;
      logic [rrlm_pkg::SLOT_W-1:0] slot;
      rec_type                     rec;
      int                          i;
      taken = 1'b0;
      case (it.op)
         rrlm_pkg::OP_CLEAR: begin
            lt_valid = 1'b0;
            expect_rsp(rrlm_pkg::KIND_CLEAR_ACK, '0, '0, '0, 1'b1, '0, '0, 1'b0);
         end
         rrlm_pkg::OP_SCAN: begin
            if (it.pos == 4'd0)
               scan_crc_acc = rrlm_pkg::CRC_INIT;
            page_img[it.pos] = it.data;
            if (it.pos < rrlm_pkg::CRC_SPAN)
               scan_crc_acc = crc16_ccitt_byte(scan_crc_acc, it.data);
            if (it.pos == rrlm_pkg::REC_LAST) begin
               magic  = {page_img[1], page_img[0]};
               seq    = {page_img[5], page_img[4], page_img[3], page_img[2]};
               val    = {page_img[9], page_img[8], page_img[7], page_img[6]};
               stored = {page_img[15], page_img[14]};
               // keep the first valid record, else only a strictly newer one
               if (magic == magic_cfg && stored == scan_crc_acc) begin
                  diff = seq - lt_seq;
                  if (!lt_valid || (diff != 0 && !diff[31])) begin
                     lt_seq   = seq;
                     lt_slot  = it.slot;
                     lt_value = val;
                     lt_valid = 1'b1;
                     taken    = 1'b1;
                  end
               end
               expect_rsp(rrlm_pkg::KIND_VERDICT, it.slot, '0, '0, 1'b1, lt_value,
                          lt_seq, taken);
            end
         end
         rrlm_pkg::OP_SAVE: begin
            if (lt_valid && it.value == lt_value) begin
               expect_rsp(rrlm_pkg::KIND_SKIPPED, lt_slot, '0, '0, 1'b1, lt_value,
                          lt_seq, 1'b1);
            end else begin
               slot = lt_valid ?
                      rrlm_pkg::SLOT_W'((int'(lt_slot) + 1) % rrlm_pkg::SLOT_COUNT) : '0;
               seq  = lt_valid ? lt_seq + 32'd1 : 32'd1;
               rec  = build_record(magic_cfg, seq, it.value);
               for (i = 0; i < rrlm_pkg::REC_BYTES; i++)
                  expect_rsp(rrlm_pkg::KIND_REC_BYTE, slot, 4'(i), rec[i],
                             i == rrlm_pkg::REC_BYTES - 1, it.value, seq, 1'b0);
               lt_slot  = slot;
               lt_seq   = seq;
               lt_value = it.value;
               lt_valid = 1'b1;
            end
         end
         default: begin
            expect_rsp(rrlm_pkg::KIND_LOAD, lt_slot, '0, '0, 1'b1,
                       lt_valid ? lt_value : '0, lt_valid ? lt_seq : '0, lt_valid);
         end
      endcase
   endtask

   // model, config capture and result check on the rising edge
   always @(posedge clock) begin
      log_req_type       it;
      rrlm_pkg::rsp_type want;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (reset) begin
         lt_seq       = '0;
         lt_slot      = '0;
         lt_value     = '0;
         lt_valid     = 1'b0;
         scan_crc_acc = rrlm_pkg::CRC_INIT;
         magic_cfg    = rrlm_pkg::MAGIC_RESET;
      end else begin
         if (csr_wr_en)
            magic_cfg = csr_wr_data;
         if (req_valid && req_ready) begin
            req_fire = 1'b1;
            accepted_count++;
            it.op    = req_op;
            it.slot  = req_slot_index;
            it.pos   = req_byte_index;
            it.data  = req_page_byte;
            it.value = req_new_value;
            predict_log_results(it);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_fire = 1'b1;
            if (expected_rsps.size() == 0) begin
               report_mismatch("result with none expected");
            end else begin
               want = expected_rsps.pop_front();
               check_field("kind", 32'(rsp_kind), 32'(want.kind));
               check_field("out_slot", 32'(rsp_out_slot), 32'(want.out_slot));
               check_field("out_byte_index", 32'(rsp_out_byte_index),
                           32'(want.out_byte_index));
               check_field("out_byte", 32'(rsp_out_byte), 32'(want.out_byte));
               check_field("last", 32'(rsp_last), 32'(want.last));
               check_field("out_value", rsp_out_value, want.out_value);
               check_field("out_sequence", rsp_out_sequence, want.out_sequence);
               check_field("flag", 32'(rsp_flag), 32'(want.flag));
            end
         end
      end
   end

   // request driver: holds an item until taken, then waits its drawn gap
   always @(negedge clock) begin
      log_req_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (tx_wait > 0) begin
         tx_wait--;
         req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         cur = pending_reqs.pop_front();
         req_op         <= cur.op;
         req_slot_index <= cur.slot;
         req_byte_index <= cur.pos;
         req_page_byte  <= cur.data;
         req_new_value  <= cur.value;
         req_valid      <= 1'b1;
         if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
         tx_wait = draw_idle(tx_calm);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result side: random stall after each item, plus the long hold
   always @(negedge clock) begin
      if (rsp_fire) begin
         if ($urandom_range(0, 15) == 0)
            rx_calm = !rx_calm;
         rx_wait = draw_idle(rx_calm);
      end
      if (hold_on) begin
         rsp_ready <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // long receiver hold while the sender keeps offering items
   initial begin
      wait (accepted_count >= 90);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (400) @(posedge clock);
      hold_on = 1'b0;
   end

   task automatic queue_item(logic [1:0] op, logic [rrlm_pkg::SLOT_W-1:0] slot,
                             logic [3:0] pos, logic [7:0] data, logic [31:0] value);
      log_req_type it;
      it.op    = op;
      it.slot  = slot;
      it.pos   = pos;
      it.data  = data;
      it.value = value;
      pending_reqs.push_back(it);
      pushed_count++;
   endtask

   // non-scan item with random don't-care fields
   task automatic queue_other(logic [1:0] op, logic [31:0] value);
      queue_item(op, rrlm_pkg::SLOT_W'($urandom), 4'($urandom), 8'($urandom), value);
   endtask

   // a whole page scan, optionally with one bit flipped
   task automatic queue_record(logic [rrlm_pkg::SLOT_W-1:0] slot, logic [15:0] magic,
                               logic [31:0] seq, logic [31:0] value, logic damage);
      rec_type rec;
      int      pos;
      int      i;
      rec = build_record(magic, seq, value);
      if (damage) begin
         pos = $urandom_range(0, 15);
         rec[pos] = rec[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      for (i = 0; i < rrlm_pkg::REC_BYTES; i++)
         queue_item(rrlm_pkg::OP_SCAN, slot, 4'(i), rec[i], $urandom);
   endtask

   function automatic logic [31:0] extreme_value();
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // mostly well-formed record scans and saves, with loads, clears and noise
   task automatic random_phase(int target, logic [15:0] magic);
      int          start;
      int          pick;
      int          n;
      int          k;
      logic [31:0] seq;
      logic [31:0] val;
      start = pushed_count;
      while (pushed_count - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            case ($urandom_range(0, 5))
               0:       seq = seq_hint + 32'd1;
               1:       seq = seq_hint + $urandom_range(2, 5000);
               2:       seq = seq_hint - $urandom_range(1, 5000);
               3:       seq = seq_hint;
               4:       seq = $urandom;
               default: seq = seq_hint + 32'h8000_0000;
            endcase
            val = ($urandom_range(0, 5) == 0) ? extreme_value() : $urandom;
            queue_record(rrlm_pkg::SLOT_W'($urandom),
                         ($urandom_range(0, 7) == 0) ? 16'($urandom) : magic,
                         seq, val, $urandom_range(0, 4) == 0);
            if (seq - seq_hint < 32'h8000_0000) begin
               seq_hint   = seq;
               value_hint = val;
            end
         end else if (pick < 60) begin
            case ($urandom_range(0, 3))
               0:       val = value_hint;
               1:       val = extreme_value();
               default: val = $urandom;
            endcase
            queue_other(rrlm_pkg::OP_SAVE, val);
            value_hint = val;
            seq_hint   = seq_hint + 32'd1;
         end else if (pick < 75) begin
            queue_other(rrlm_pkg::OP_LOAD, $urandom);
         end else if (pick < 83) begin
            queue_other(rrlm_pkg::OP_CLEAR, $urandom);
         end else begin
            // stray and out-of-order page bytes
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
               queue_item(rrlm_pkg::OP_SCAN, rrlm_pkg::SLOT_W'($urandom), 4'($urandom),
                          8'($urandom), $urandom);
         end
      end
   endtask

   // every queued item taken and every result seen, then let the core settle
   task automatic wait_idle();
      while (accepted_count != pushed_count || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_magic(logic [15:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // phase with a random magic word
   task automatic val_magic_phase();
      logic [15:0] m;
      m = 16'($urandom);
      write_magic(m);
      random_phase(55, m);
      wait_idle();
   endtask

   // stimulus sequence
   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty load, first save, skip, clear, wrapping scan and save
      queue_other(rrlm_pkg::OP_LOAD, 32'h0);
      queue_other(rrlm_pkg::OP_SAVE, 32'h8000_0000);
      queue_other(rrlm_pkg::OP_SAVE, 32'h8000_0000);
      queue_other(rrlm_pkg::OP_CLEAR, 32'hFFFF_FFFF);
      queue_other(rrlm_pkg::OP_LOAD, 32'h0);
      queue_record(7'd127, rrlm_pkg::MAGIC_RESET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      queue_other(rrlm_pkg::OP_SAVE, 32'hFFFF_FFFF);
      queue_other(rrlm_pkg::OP_LOAD, 32'h0);
      seq_hint   = 32'h0;
      value_hint = 32'hFFFF_FFFF;
      wait_idle();

      write_magic(16'h0000);
      random_phase(50, 16'h0000);
      wait_idle();

      write_magic(16'hFFFF);
      random_phase(50, 16'hFFFF);
      wait_idle();

      val_magic_phase();

      write_magic(rrlm_pkg::MAGIC_RESET);
      random_phase(50, rrlm_pkg::MAGIC_RESET);
      wait_idle();
      repeat (20) @(negedge clock);

      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("ring_record_log_manager_core verification clean");
      else
         $display("ring_record_log_manager_core verification failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/rrlm_pkg.sv
rtl/ring_record_log_manager_core.sv
tb/ring_record_log_manager_core_tb.sv
